@@ hdl/spq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 256;
  localparam int unsigned DEF_HANDLE_BITS = 9;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned CAP_W   = 9;
  localparam int unsigned TOTAL_W = 9;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic             enq;
    logic             deq;
    logic [KEY_W-1:0] key;
  } spq_ctrl_t;

endpackage
`default_nettype wire

@@ hdl/spq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire spq_ctrl_t              ctrl,
  input  wire logic [HANDLE_BITS-1:0] new_handle,
  // left neighbor (toward the head)
  input  wire logic [KEY_W-1:0]       prev_key,
  input  wire logic [HANDLE_BITS-1:0] prev_handle,
  input  wire logic                   prev_occ,
  input  wire logic                   prev_keep,
  // right neighbor (toward the tail)
  input  wire logic [KEY_W-1:0]       next_key,
  input  wire logic [HANDLE_BITS-1:0] next_handle,
  input  wire logic                   next_occ,
  output logic [KEY_W-1:0]            key,
  output logic [HANDLE_BITS-1:0]      handle,
  output logic                        occ,
  output logic                        keep
);

  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [HANDLE_BITS-1:0] hnd_r, hnd_nxt;
  logic                   occ_r, occ_nxt;
  logic                   take_new;

  // held entries sorted, so keep forms a prefix of the chain
  assign keep     = occ_r && (key_r <= ctrl.key);
  assign take_new = !keep && prev_keep;

  always_comb begin
    key_nxt = key_r;
    hnd_nxt = hnd_r;
    occ_nxt = occ_r;
    if (ctrl.enq) begin
      occ_nxt = prev_occ;
      if (keep) begin
        key_nxt = key_r;
        hnd_nxt = hnd_r;
      end else if (take_new) begin
        key_nxt = ctrl.key;
        hnd_nxt = new_handle;
      end else begin
        key_nxt = prev_key;
        hnd_nxt = prev_handle;
      end
    end else if (ctrl.deq) begin
      occ_nxt = next_occ;
      key_nxt = next_key;
      hnd_nxt = next_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    hnd_r <= hnd_nxt;
  end

  assign key    = key_r;
  assign handle = hnd_r;
  assign occ    = occ_r;

endmodule
`default_nettype wire

@@ hdl/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sorted min-priority queue built as a chain of QUEUE_DEPTH cells.
// Input channel (in_valid/in_stall): one word per operation, in_opcode selects
// enqueue (in_key, in_node_handle) or dequeue. Each word yields exactly one
// result word on the output channel (out_valid/out_stall) carrying accepted,
// the dequeued key/handle (0 otherwise), and count/empty/full afterward.
// Equal keys leave in arrival order. Enqueue is refused when the count has
// reached min(capacity_limit, QUEUE_DEPTH); dequeue is refused when empty.
// The result is registered. Throughput is one word per cycle while the
// receiver does not stall: every cell compares against the broadcast key and
// loads its own, its neighbor's or the new entry in the same cycle.
// When the receiver stalls, the result stays in the output register and
// in_stall is raised until it is taken.
// Reset (rst_n low, synchronous) empties the queue and sets capacity_limit
// to 256; no clearing pass is needed. capacity_limit, at APB byte address 0,
// is for the user to write only while the queue is idle; not enforced.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int unsigned HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ADDR_W-1:0]      paddr,
  input  wire logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]           prdata,
  output logic                        pready,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_opcode,
  input  wire logic [KEY_W-1:0]       in_key,
  input  wire logic [HANDLE_BITS-1:0] in_node_handle,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_accepted,
  output logic [KEY_W-1:0]            out_key,
  output logic [HANDLE_BITS-1:0]      out_handle,
  output logic [TOTAL_W-1:0]          out_entry_total,
  output logic                        out_is_empty,
  output logic                        out_is_full
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(QUEUE_DEPTH);

  // ---------------- configuration ----------------
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(cap_r) : '0;
  assign cap_nxt = cfg_wr ? pwdata[CAP_W-1:0] : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  // ---------------- count and decision ----------------
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CMP_W-1:0] cap_ext, eff_cap, cnt_ext, cnt_nxt_ext;
  logic             in_go, enq_ok, deq_ok;
  spq_ctrl_t        ctrl;

  assign in_stall = out_valid && out_stall;
  assign in_go    = in_valid && !in_stall;

  assign cap_ext = CMP_W'(cap_r);
  assign eff_cap = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
  assign cnt_ext = CMP_W'(cnt_r);

  assign enq_ok = (in_opcode == OP_ENQUEUE) && (cnt_ext < eff_cap);
  assign deq_ok = (in_opcode == OP_DEQUEUE) && (cnt_r != '0);

  assign ctrl.enq = in_go && enq_ok;
  assign ctrl.deq = in_go && deq_ok;
  assign ctrl.key = in_key;

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.enq) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctrl.deq) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end
  assign cnt_nxt_ext = CMP_W'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // ---------------- cell chain ----------------
  logic [KEY_W-1:0]       key_q  [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] hnd_q  [QUEUE_DEPTH];
  logic                   occ_q  [QUEUE_DEPTH];
  logic                   keep_q [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0]       p_key, n_key;
    logic [HANDLE_BITS-1:0] p_hnd, n_hnd;
    logic                   p_occ, p_keep, n_occ;

    if (i == 0) begin : g_head
      assign p_key  = in_key;
      assign p_hnd  = in_node_handle;
      assign p_occ  = 1'b1;
      assign p_keep = 1'b1;
    end else begin : g_body
      assign p_key  = key_q[i-1];
      assign p_hnd  = hnd_q[i-1];
      assign p_occ  = occ_q[i-1];
      assign p_keep = keep_q[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign n_key = key_q[i];
      assign n_hnd = hnd_q[i];
      assign n_occ = 1'b0;
    end else begin : g_mid
      assign n_key = key_q[i+1];
      assign n_hnd = hnd_q[i+1];
      assign n_occ = occ_q[i+1];
    end

    spq_cell #(
      .HANDLE_BITS(HANDLE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_handle (in_node_handle),
      .prev_key   (p_key),
      .prev_handle(p_hnd),
      .prev_occ   (p_occ),
      .prev_keep  (p_keep),
      .next_key   (n_key),
      .next_handle(n_hnd),
      .next_occ   (n_occ),
      .key        (key_q[i]),
      .handle     (hnd_q[i]),
      .occ        (occ_q[i]),
      .keep       (keep_q[i])
    );
  end

  // ---------------- result register ----------------
  logic                   out_valid_r, out_valid_nxt;
  logic                   acc_r;
  logic [KEY_W-1:0]       okey_r;
  logic [HANDLE_BITS-1:0] ohnd_r;
  logic [TOTAL_W-1:0]     total_r;
  logic                   empty_r, full_r;

  assign out_valid_nxt = in_go ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      acc_r   <= ctrl.enq || ctrl.deq;
      okey_r  <= ctrl.deq ? key_q[0] : '0;
      ohnd_r  <= ctrl.deq ? hnd_q[0] : '0;
      total_r <= cnt_nxt_ext[TOTAL_W-1:0];
      empty_r <= (cnt_nxt == '0);
      full_r  <= (cnt_nxt_ext >= eff_cap);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = acc_r;
  assign out_key         = okey_r;
  assign out_handle      = ohnd_r;
  assign out_entry_total = total_r;
  assign out_is_empty    = empty_r;
  assign out_is_full     = full_r;

  // ---------------- assertions ----------------
  a_head_occ: assert property (@(posedge clk) disable iff (!rst_n)
    occ_q[0] == (cnt_r != '0))
    else $error("head cell occupancy disagrees with count");

  a_tail_occ: assert property (@(posedge clk) disable iff (!rst_n)
    occ_q[QUEUE_DEPTH-1] == (CMP_W'(cnt_r) == DEPTH_C))
    else $error("tail cell occupancy disagrees with count");

  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    occ_q[1] |-> (key_q[0] <= key_q[1]))
    else $error("head pair out of order");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.enq |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("count did not rise on enqueue");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !acc_r) |-> (okey_r == '0 && ohnd_r == '0))
    else $error("refused result carries data");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top
  import spq_pkg::*;
();

  localparam int DEPTH = DEF_QUEUE_DEPTH;
  localparam int HB    = DEF_HANDLE_BITS;
  // far above the slowest legal run: ~1500 words, long stalls, one hold-off
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [HB-1:0]    hnd;
  } op_word_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic [HB-1:0]    hnd;
  } entry_t;

  typedef struct {
    logic               acc;
    logic [KEY_W-1:0]   key;
    logic [HB-1:0]      hnd;
    logic [TOTAL_W-1:0] total;
    logic               empty;
    logic               full;
  } result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_opcode = OP_ENQUEUE;
  logic [KEY_W-1:0]   in_key = '0;
  logic [HB-1:0]      in_node_handle = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_accepted;
  logic [KEY_W-1:0]   out_key;
  logic [HB-1:0]      out_handle;
  logic [TOTAL_W-1:0] out_entry_total;
  logic               out_is_empty;
  logic               out_is_full;

  op_word_t    op_backlog[$];
  result_t     owed_results[$];
  entry_t      model_entries[$];
  logic [CAP_W-1:0] model_cap = CAP_RESET;

  int          tx_pct = 0;
  int          rx_pct = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          errors = 0;
  int unsigned cycle_cnt = 0;

  sorted_priority_queue uut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_key(in_key), .in_node_handle(in_node_handle),
    .out_valid(out_valid), .out_stall(out_stall), .out_accepted(out_accepted),
    .out_key(out_key), .out_handle(out_handle), .out_entry_total(out_entry_total),
    .out_is_empty(out_is_empty), .out_is_full(out_is_full)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ordered insert after all keys <= new key, pop from the head
  function automatic result_t sorted_queue_apply(logic op, logic [KEY_W-1:0] key,
                                                 logic [HB-1:0] hnd);
    result_t r;
    entry_t  e;
    int      lim;
    int      pos;
    r = '{default: '0};
    lim = (model_cap > DEPTH) ? DEPTH : int'(model_cap);
    if (op == OP_ENQUEUE) begin
      if (model_entries.size() < lim) begin
        pos = 0;
        while (pos < model_entries.size() && model_entries[pos].key <= key) pos++;
        e.key = key;
        e.hnd = hnd;
        model_entries.insert(pos, e);
        r.acc = 1'b1;
      end
    end else if (model_entries.size() > 0) begin
      e = model_entries.pop_front();
      r.acc = 1'b1;
      r.key = e.key;
      r.hnd = e.hnd;
    end
    r.total = TOTAL_W'(model_entries.size());
    r.empty = (model_entries.size() == 0);
    r.full  = (model_entries.size() >= lim);
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return KEY_W'($urandom_range(15)); // lots of ties
      default: return KEY_W'($urandom);
    endcase
  endfunction

  function automatic void queue_word(logic op, logic [KEY_W-1:0] key, logic [HB-1:0] hnd);
    op_word_t w;
    w.op  = op;
    w.key = key;
    w.hnd = hnd;
    op_backlog.push_back(w);
  endfunction

  // sender
  always @(posedge clk) begin : drv
    op_word_t nxt;
    logic     took;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) owed_results.push_back(sorted_queue_apply(in_opcode, in_key, in_node_handle));
      if (!in_valid || took) begin
        if (op_backlog.size() > 0 && $urandom_range(99) >= tx_pct) begin
          nxt = op_backlog.pop_front();
          in_valid       <= 1'b1;
          in_opcode      <= nxt.op;
          in_key         <= nxt.key;
          in_node_handle <= nxt.hnd;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  // result checker
  always @(posedge clk) begin : mon
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = owed_results.pop_front();
        if (out_accepted !== e.acc) begin
          $error("accepted: expected %0d, got %0d", e.acc, out_accepted);
          errors++;
        end
        if (out_key !== e.key) begin
          $error("out_key: expected %0h, got %0h", e.key, out_key);
          errors++;
        end
        if (out_handle !== e.hnd) begin
          $error("out_handle: expected %0h, got %0h", e.hnd, out_handle);
          errors++;
        end
        if (out_entry_total !== e.total) begin
          $error("entry_total: expected %0d, got %0d", e.total, out_entry_total);
          errors++;
        end
        if (out_is_empty !== e.empty) begin
          $error("is_empty: expected %0d, got %0d", e.empty, out_is_empty);
          errors++;
        end
        if (out_is_full !== e.full) begin
          $error("is_full: expected %0d, got %0d", e.full, out_is_full);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** sorted_priority_queue: FAILED **");
      $finish;
    end
  end

  task automatic write_capacity(input logic [CAP_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(REG_CAPACITY) << 2;
    pwdata  <= DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model_cap = val;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (op_backlog.size() != 0 || in_valid || owed_results.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic start_phase(input logic [CAP_W-1:0] cap, input int tx, input int rx);
    write_capacity(cap);
    @(negedge clk);
    tx_pct = tx;
    rx_pct = rx;
  endtask

  task automatic random_phase(input logic [CAP_W-1:0] cap, input int tx, input int rx,
                              input int n, input int enq_pct, input bit long_hold);
    start_phase(cap, tx, rx);
    if (long_hold) hold_requests++;
    repeat (n) begin
      queue_word(($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE,
                 rand_key(), HB'($urandom));
    end
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // capacity above depth; ties keep arrival order; extremes of key and handle
    start_phase(9'd511, 0, 0);
    queue_word(OP_DEQUEUE, '1, '1);
    queue_word(OP_ENQUEUE, '0, '0);
    queue_word(OP_ENQUEUE, '1, '1);
    queue_word(OP_ENQUEUE, 32'd5, 9'd1);
    queue_word(OP_ENQUEUE, 32'd5, 9'd2);
    queue_word(OP_ENQUEUE, '0, '1);
    repeat (6) queue_word(OP_DEQUEUE, rand_key(), HB'($urandom));
    wait_idle();

    // capacity of one
    start_phase(9'd1, 0, 0);
    queue_word(OP_ENQUEUE, 32'd7, 9'd100);
    queue_word(OP_ENQUEUE, 32'd3, 9'd101);
    queue_word(OP_DEQUEUE, '0, '0);
    queue_word(OP_DEQUEUE, '0, '0);
    wait_idle();

    // capacity zero: always full
    start_phase(9'd0, 0, 0);
    queue_word(OP_ENQUEUE, 32'd1, 9'd5);
    queue_word(OP_DEQUEUE, '0, '0);
    wait_idle();

    // fill a few, then drop capacity below the count
    start_phase(9'd256, 0, 0);
    queue_word(OP_ENQUEUE, 32'd9, 9'd10);
    queue_word(OP_ENQUEUE, 32'd3, 9'd11);
    queue_word(OP_ENQUEUE, 32'd9, 9'd12);
    queue_word(OP_ENQUEUE, 32'd1, 9'd13);
    wait_idle();
    start_phase(9'd2, 0, 0);
    queue_word(OP_ENQUEUE, 32'd0, 9'd14);
    repeat (3) queue_word(OP_DEQUEUE, '0, '0);
    queue_word(OP_ENQUEUE, 32'd2, 9'd15);
    repeat (2) queue_word(OP_DEQUEUE, '0, '0);
    wait_idle();

    // random traffic
    random_phase(9'd511, 0, 0, 380, 90, 1'b0);     // runs into full
    random_phase(9'd256, 45, 0, 200, 30, 1'b0);
    random_phase(9'd1, 0, 45, 100, 50, 1'b0);
    random_phase(CAP_W'($urandom_range(2, 255)), 7, 7, 250, 60, 1'b0);
    random_phase(9'd256, 0, 0, 200, 55, 1'b1);     // long receiver hold-off
    random_phase(9'd0, 0, 45, 50, 50, 1'b0);
    random_phase(9'd256, 45, 0, 150, 50, 1'b0);
    random_phase(CAP_W'($urandom_range(1, 511)), 7, 7, 120, 45, 1'b0);

    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("** sorted_priority_queue: PASSED **");
    end else begin
      $display("** sorted_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule
